/* design/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types for the modular exponentiation block: widths,
// register indexes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int KEY_BITS  = 32;
  localparam int MSG_W     = 8;
  localparam int OUT_W     = 32;
  localparam int CNT_W     = $clog2(KEY_BITS);
  localparam int MSG_IDX_W = $clog2(MSG_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_INIT,
    S_CHECK,
    S_MUL_ACC,
    S_STORE_ACC,
    S_START_SQR,
    S_MUL_SQR,
    S_STORE_BASE,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_RED_STEP,
    DP_INIT,
    DP_START_ACC,
    DP_START_SQR,
    DP_MUL_STEP,
    DP_STORE_ACC,
    DP_STORE_BASE,
    DP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_one;   // configured exponent is one
    logic exp_zero;  // no exponent bits left
    logic exp_lsb;   // current exponent bit
    logic red_last;  // last message bit of the reduction
    logic mul_last;  // last multiplier bit of a product
  } dp_status_t;

endpackage

/* design/mexp_datapath.sv */
// ----------------------------------------------------------------------------
// mexp_datapath
// Key registers, message reduction and a shift-add modular multiplier that
// handles one multiplier bit per cycle, plus the result register.
// ----------------------------------------------------------------------------
module mexp_datapath
  import mexp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_BITS-1:0]  cfg_data,
  input  logic [MSG_W-1:0]     message,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic [OUT_W-1:0]     cipher_value
);

  logic [KEY_BITS-1:0]  exponent;
  logic [KEY_BITS-1:0]  modulus;
  logic [MSG_W-1:0]     msg;
  logic [KEY_BITS-1:0]  exp_sr;
  logic [KEY_BITS-1:0]  base;
  logic [KEY_BITS-1:0]  acc;
  logic [KEY_BITS-1:0]  x;
  logic [KEY_BITS-1:0]  y;
  logic [KEY_BITS-1:0]  p;
  logic [CNT_W-1:0]     cnt;

  logic                 mod_zero;
  logic                 mod_one;
  logic                 msg_bit;
  logic [KEY_BITS:0]    red_sum;
  logic [KEY_BITS:0]    red_mod;
  logic [KEY_BITS-1:0]  red_next;
  logic [KEY_BITS+1:0]  mul_sum;
  logic [KEY_BITS+1:0]  mul_m1;
  logic [KEY_BITS+1:0]  mul_m2;
  logic [KEY_BITS+1:0]  mul_d1;
  logic [KEY_BITS+1:0]  mul_d2;
  logic [KEY_BITS-1:0]  mul_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= KEY_BITS'(1);
      modulus  <= KEY_BITS'(64'hFFFF_FFFF);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXPONENT: exponent <= cfg_data;
        REG_MODULUS:  modulus  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mod_zero = (modulus == '0);
  assign mod_one  = (modulus == KEY_BITS'(1));

  // remainder of the message, one message bit a cycle from the top
  assign msg_bit  = msg[MSG_IDX_W'(MSG_W-1) - cnt[MSG_IDX_W-1:0]];
  assign red_sum  = {p, msg_bit};
  assign red_mod  = {1'b0, modulus};
  assign red_next = (red_sum >= red_mod) ? KEY_BITS'(red_sum - red_mod)
                                         : KEY_BITS'(red_sum);

  // 2p + bit*x stays below 3m, so one of three candidates is the residue
  assign mul_sum  = {1'b0, p, 1'b0} + (y[KEY_BITS-1] ? {2'b00, x} : '0);
  assign mul_m1   = {2'b00, modulus};
  assign mul_m2   = {1'b0, modulus, 1'b0};
  assign mul_d1   = mul_sum - mul_m1;
  assign mul_d2   = mul_sum - mul_m2;

  always_comb begin
    if (mod_zero) begin
      mul_next = KEY_BITS'(mul_sum);
    end else if (mul_sum >= mul_m2) begin
      mul_next = KEY_BITS'(mul_d2);
    end else if (mul_sum >= mul_m1) begin
      mul_next = KEY_BITS'(mul_d1);
    end else begin
      mul_next = KEY_BITS'(mul_sum);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_NONE: ;
      DP_LOAD: begin
        msg    <= message;
        exp_sr <= exponent;
        p      <= '0;
        cnt    <= '0;
      end
      DP_RED_STEP: begin
        p   <= red_next;
        cnt <= cnt + CNT_W'(1);
      end
      DP_INIT: begin
        base <= mod_zero ? KEY_BITS'(msg) : p;
        acc  <= mod_one ? '0 : KEY_BITS'(1);
      end
      DP_START_ACC: begin
        x   <= acc;
        y   <= base;
        p   <= '0;
        cnt <= '0;
      end
      DP_START_SQR: begin
        x   <= base;
        y   <= base;
        p   <= '0;
        cnt <= '0;
      end
      DP_MUL_STEP: begin
        p   <= mul_next;
        y   <= {y[KEY_BITS-2:0], 1'b0};
        cnt <= cnt + CNT_W'(1);
      end
      DP_STORE_ACC:  acc <= p;
      DP_STORE_BASE: begin
        base   <= p;
        exp_sr <= {1'b0, exp_sr[KEY_BITS-1:1]};
      end
      DP_LOAD_OUT: cipher_value <= status.exp_one ? OUT_W'(msg) : OUT_W'(acc);
      default: ;
    endcase
  end

  always_comb begin
    status.exp_one  = (exponent == KEY_BITS'(1));
    status.exp_zero = (exp_sr == '0);
    status.exp_lsb  = exp_sr[0];
    status.red_last = (cnt == CNT_W'(MSG_W-1));
    status.mul_last = (cnt == CNT_W'(KEY_BITS-1));
  end

endmodule

/* design/mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for square-and-multiply: steps the datapath through message
// reduction, the products for each exponent bit and the result hand-off.
// ----------------------------------------------------------------------------
module mexp_ctrl
  import mexp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = DP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = status.exp_one ? S_FINISH : S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.op = DP_RED_STEP;
        if (status.red_last) state_next = S_INIT;
      end
      S_INIT: begin
        cmd.op     = DP_INIT;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.exp_zero) begin
          state_next = S_FINISH;
        end else if (status.exp_lsb) begin
          cmd.op     = DP_START_ACC;
          state_next = S_MUL_ACC;
        end else begin
          cmd.op     = DP_START_SQR;
          state_next = S_MUL_SQR;
        end
      end
      S_MUL_ACC: begin
        cmd.op = DP_MUL_STEP;
        if (status.mul_last) state_next = S_STORE_ACC;
      end
      S_STORE_ACC: begin
        cmd.op     = DP_STORE_ACC;
        state_next = S_START_SQR;
      end
      S_START_SQR: begin
        cmd.op     = DP_START_SQR;
        state_next = S_MUL_SQR;
      end
      S_MUL_SQR: begin
        cmd.op = DP_MUL_STEP;
        if (status.mul_last) state_next = S_STORE_BASE;
      end
      S_STORE_BASE: begin
        cmd.op     = DP_STORE_BASE;
        state_next = S_CHECK;
      end
      S_FINISH: begin
        // wait for the result slot to free up
        if (!out_valid || out_ready) begin
          cmd.op     = DP_LOAD_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = (cmd.op == DP_LOAD_OUT) || (out_valid && !out_ready);

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_LOAD_OUT) |-> (!out_valid || out_ready))
    else $error("result register loaded while an unread beat waits");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new beat accepted while an item is in progress");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == DP_LOAD_OUT))
    else $error("output valid raised without a result load");

endmodule

/* design/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation
// Raises each message byte to the configured exponent modulo the configured
// modulus by right-to-left square-and-multiply; exponent one returns the byte.
// ----------------------------------------------------------------------------
// latency with exponent one: the beat goes from S_IDLE straight to S_FINISH
// otherwise reduction, then a product per clear exponent bit and two per set bit
// each product on the shift-add multiplier, one multiplier bit per cycle
// one item at a time; the next beat is taken once the result is registered
// rst (synchronous) sets exponent to 1 and modulus to 0xFFFFFFFF, empties output
module modular_exponentiation
  import mexp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_BITS-1:0]  cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [MSG_W-1:0]     s_axis_tdata,   // [7:0] message
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata    // [31:0] cipher_value
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .message      (s_axis_tdata),
    .cmd          (cmd),
    .status       (status),
    .cipher_value (m_axis_tdata)
  );

endmodule
